@@ rtl/otsl_pkg.sv @@
// ----------------------------------------------------------------------------
// otsl_pkg
// Shared types and constants of the onset-triggered stutter looper.
// ----------------------------------------------------------------------------
package otsl_pkg;

  localparam int unsigned LOOP_DEPTH_DEF  = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned ONSET_THRESHOLD_W = 25;
  localparam int unsigned LOOP_SAMPLES_W    = 17;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 25;

  localparam logic [ONSET_THRESHOLD_W-1:0] ONSET_THRESHOLD_RST = ONSET_THRESHOLD_W'(8389);
  localparam logic [LOOP_SAMPLES_W-1:0]    LOOP_SAMPLES_RST    = LOOP_SAMPLES_W'(12000);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_REC  = 2'd2,
    MODE_PLAY = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONSET_THRESHOLD = 1'd0,
    CFG_LOOP_SAMPLES    = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic  wr;
    logic  rd;
    mode_e mode;
  } otsl_step_t;

endpackage

@@ rtl/otsl_in_if.sv @@
// ----------------------------------------------------------------------------
// otsl_in_if
// Input channel: one stereo sample pair and the arm flag per beat.
// ----------------------------------------------------------------------------
interface otsl_in_if #(
  parameter int unsigned SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;
  logic                          arm;

  modport source (output valid, in_left, in_right, arm, input ready);
  modport sink   (input valid, in_left, in_right, arm, output ready);
endinterface

@@ rtl/otsl_out_if.sv @@
// ----------------------------------------------------------------------------
// otsl_out_if
// Output channel: one stereo sample pair and the mode per beat.
// ----------------------------------------------------------------------------
interface otsl_out_if #(
  parameter int unsigned SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  otsl_pkg::mode_e               mode;

  modport source (output valid, out_left, out_right, mode, input ready);
  modport sink   (input valid, out_left, out_right, mode, output ready);
endinterface

@@ rtl/otsl_cfg_if.sv @@
// ----------------------------------------------------------------------------
// otsl_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface otsl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [otsl_pkg::CFG_IDX_W-1:0]      index;
  logic [otsl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/otsl_ram.sv @@
// ----------------------------------------------------------------------------
// otsl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module otsl_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = otsl_pkg::LOOP_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/otsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// otsl_ctrl
// Looper sequencer: onset detection, loop length latch, loop position and
// loop store access per accepted beat.
// ----------------------------------------------------------------------------
module otsl_ctrl #(
  parameter int unsigned LOOP_DEPTH  = otsl_pkg::LOOP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_fire_i,
  input  logic signed [SAMPLE_BITS-1:0]               in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]               in_right_i,
  input  logic                                        arm_i,
  input  logic [otsl_pkg::ONSET_THRESHOLD_W-1:0]      onset_threshold_i,
  input  logic [otsl_pkg::LOOP_SAMPLES_W-1:0]         loop_samples_i,
  output otsl_pkg::otsl_step_t                        step_o,
  output logic [$clog2(LOOP_DEPTH)-1:0]               addr_o
);

  localparam int unsigned ADDR_W = $clog2(LOOP_DEPTH);
  localparam int unsigned POS_W  = $clog2(LOOP_DEPTH + 1);
  localparam int unsigned LS_W   = otsl_pkg::LOOP_SAMPLES_W;
  localparam int unsigned LEN_W  = (POS_W > LS_W) ? POS_W : LS_W;
  localparam int unsigned ENV_W  = SAMPLE_BITS + 1;
  localparam int unsigned THR_W  = otsl_pkg::ONSET_THRESHOLD_W;
  localparam int unsigned CMP_W  = (ENV_W > THR_W) ? ENV_W : THR_W;

  localparam logic [LEN_W-1:0] DEPTH_EXT = LEN_W'(LOOP_DEPTH);

  otsl_pkg::mode_e  mode_q, mode_d, mode_cur;
  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [POS_W-1:0] len_q, len_d;
  logic [ENV_W-1:0] prev_q, prev_d;

  logic [SAMPLE_BITS-1:0] raw_l, raw_r, mag_l, mag_r;
  logic [ENV_W-1:0]       env;
  logic [CMP_W-1:0]       env_ext, prev_ext, thr_ext;
  logic [LEN_W-1:0]       ls_ext, len_clamped;
  logic                   onset;

  always_comb begin
    raw_l    = in_left_i;
    raw_r    = in_right_i;
    mag_l    = raw_l[SAMPLE_BITS-1] ? (~raw_l + SAMPLE_BITS'(1)) : raw_l;
    mag_r    = raw_r[SAMPLE_BITS-1] ? (~raw_r + SAMPLE_BITS'(1)) : raw_r;
    env      = {1'b0, mag_l} + {1'b0, mag_r};
    env_ext  = CMP_W'(env);
    prev_ext = CMP_W'(prev_q);
    thr_ext  = CMP_W'(onset_threshold_i);
    onset    = (env_ext > thr_ext) && (prev_ext <= thr_ext);

    ls_ext = LEN_W'(loop_samples_i);
    if (ls_ext > DEPTH_EXT) begin
      len_clamped = DEPTH_EXT;
    end else if (ls_ext == '0) begin
      len_clamped = LEN_W'(1);
    end else begin
      len_clamped = ls_ext;
    end

    if (!arm_i) begin
      mode_cur = otsl_pkg::MODE_IDLE;
    end else if (mode_q == otsl_pkg::MODE_IDLE) begin
      mode_cur = otsl_pkg::MODE_WAIT;
    end else begin
      mode_cur = mode_q;
    end

    pos_inc     = pos_q + POS_W'(1);
    mode_d      = mode_q;
    pos_d       = pos_q;
    len_d       = len_q;
    prev_d      = prev_q;
    step_o.wr   = 1'b0;
    step_o.rd   = 1'b0;
    step_o.mode = mode_cur;

    if (in_fire_i) begin
      mode_d = mode_cur;
      prev_d = '0;
      unique case (mode_cur)
        otsl_pkg::MODE_IDLE: begin
        end
        otsl_pkg::MODE_WAIT: begin
          prev_d = env;
          if (onset) begin
            len_d  = POS_W'(len_clamped);
            pos_d  = '0;
            mode_d = otsl_pkg::MODE_REC;
          end
        end
        otsl_pkg::MODE_REC: begin
          step_o.wr = 1'b1;
          if (pos_inc >= len_q) begin
            pos_d  = '0;
            mode_d = otsl_pkg::MODE_PLAY;
          end else begin
            pos_d = pos_inc;
          end
        end
        otsl_pkg::MODE_PLAY: begin
          step_o.rd = 1'b1;
          pos_d     = (pos_inc >= len_q) ? '0 : pos_inc;
        end
        default: begin
        end
      endcase
    end
  end

  assign addr_o = pos_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= otsl_pkg::MODE_IDLE;
      pos_q  <= '0;
      len_q  <= '0;
      prev_q <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      prev_q <= prev_d;
    end
  end

endmodule

@@ rtl/onset_triggered_stutter_looper_top.sv @@
// ----------------------------------------------------------------------------
// onset_triggered_stutter_looper_top
// Stereo stutter looper: waits for an envelope onset, records a loop into
// the loop RAM, then replays it until disarmed.
//
//   channel | dir | beat payload                    | accepted when
//   --------+-----+---------------------------------+-----------------------
//   in_i    | in  | in_left, in_right, arm          | valid && ready
//   out_o   | out | out_left, out_right, mode       | valid && ready
//   cfg_i   | in  | index, data                     | valid (ready held high)
//
// One beat per cycle sustained while out_o is ready; a result passes the RAM
// stage (the registered read of the loop RAM) and then the output register.
// Two result slots (RAM stage and output register) let input continue for
// one beat while the output is stalled.
// Reset idles the sequencer and loads the config register defaults; the loop
// RAM is not cleared, since playback only reads entries written by the
// recording.
// ----------------------------------------------------------------------------
module onset_triggered_stutter_looper_top #(
  parameter int unsigned LOOP_DEPTH  = otsl_pkg::LOOP_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = otsl_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  otsl_in_if.sink    in_i,
  otsl_out_if.source out_o,
  otsl_cfg_if.sink   cfg_i
);

  localparam int unsigned ADDR_W = $clog2(LOOP_DEPTH);
  localparam int unsigned RAM_W  = 2 * SAMPLE_BITS;

  logic [otsl_pkg::ONSET_THRESHOLD_W-1:0] thr_q;
  logic [otsl_pkg::LOOP_SAMPLES_W-1:0]    ls_q;

  otsl_pkg::otsl_step_t step;
  logic [ADDR_W-1:0]    addr;
  logic [RAM_W-1:0]     rdata;
  logic                 in_fire, s1_move;

  logic                          s1_valid_q, s1_play_q;
  otsl_pkg::mode_e               s1_mode_q;
  logic signed [SAMPLE_BITS-1:0] s1_left_q, s1_right_q;
  logic                          out_valid_q;
  otsl_pkg::mode_e               out_mode_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= otsl_pkg::ONSET_THRESHOLD_RST;
      ls_q  <= otsl_pkg::LOOP_SAMPLES_RST;
    end else if (cfg_i.valid) begin
      unique case (otsl_pkg::cfg_idx_e'(cfg_i.index))
        otsl_pkg::CFG_ONSET_THRESHOLD: thr_q <= cfg_i.data[otsl_pkg::ONSET_THRESHOLD_W-1:0];
        otsl_pkg::CFG_LOOP_SAMPLES:    ls_q  <= cfg_i.data[otsl_pkg::LOOP_SAMPLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_fire    = in_i.valid && in_i.ready;

  otsl_ctrl #(
    .LOOP_DEPTH  (LOOP_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_fire_i         (in_fire),
    .in_left_i         (in_i.in_left),
    .in_right_i        (in_i.in_right),
    .arm_i             (in_i.arm),
    .onset_threshold_i (thr_q),
    .loop_samples_i    (ls_q),
    .step_o            (step),
    .addr_o            (addr)
  );

  otsl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LOOP_DEPTH)
  ) u_loop_ram (
    .clk_i   (clk_i),
    .we_i    (step.wr),
    .waddr_i (addr),
    .wdata_i ({in_i.in_left, in_i.in_right}),
    .re_i    (step.rd),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_play_q  <= step.rd;
      s1_mode_q  <= step.mode;
      s1_left_q  <= in_i.in_left;
      s1_right_q <= in_i.in_right;
    end
    if (s1_move) begin
      out_mode_q  <= s1_mode_q;
      out_left_q  <= s1_play_q ? rdata[RAM_W-1:SAMPLE_BITS] : s1_left_q;
      out_right_q <= s1_play_q ? rdata[SAMPLE_BITS-1:0]     : s1_right_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;
  assign out_o.mode      = out_mode_q;

endmodule

@@ sim/onset_triggered_stutter_looper_top_tb.sv @@
// ----------------------------------------------------------------------------
// onset_triggered_stutter_looper_top_tb
// Self-checking bench for the stutter looper. Sample pairs and the arm flag
// go in over the input channel, and both registers are written between
// phases. Both sides idle and stall at random. A mirror of the sequencer and
// the loop store predicts each output beat, and every beat is compared field
// by field with that prediction.
// ----------------------------------------------------------------------------
module onset_triggered_stutter_looper_top_tb;
  import otsl_pkg::*;

  localparam int unsigned DEPTH        = LOOP_DEPTH_DEF;
  localparam int unsigned ENV_MAX      = 16777216;
  localparam int unsigned HALF_SCALE   = 8388608;
  localparam int unsigned RANDOM_PAIRS = 700;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  typedef struct packed {
    sample_t left;
    sample_t right;
    mode_e   mode;
  } looper_beat_t;

  class looper_mirror;
    logic [ONSET_THRESHOLD_W-1:0] threshold;
    logic [LOOP_SAMPLES_W-1:0]    loop_len;
    mode_e                        loop_mode;
    int unsigned                  pos;
    int unsigned                  latched;
    logic [24:0]                  prev_env;
    sample_t                      store_l [DEPTH];
    sample_t                      store_r [DEPTH];
    looper_beat_t                 due_beats [$];
    int unsigned                  mismatches;

    function new();
      threshold  = ONSET_THRESHOLD_RST;
      loop_len   = LOOP_SAMPLES_RST;
      loop_mode  = MODE_IDLE;
      pos        = 0;
      latched    = 0;
      prev_env   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ONSET_THRESHOLD: threshold = value[ONSET_THRESHOLD_W-1:0];
        CFG_LOOP_SAMPLES:    loop_len  = value[LOOP_SAMPLES_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [24:0] magnitude(sample_t s);
      return s[SAMPLE_BITS_DEF-1] ? 25'(25'h1000000 - {1'b0, s}) : {1'b0, s};
    endfunction

    function void take_pair(sample_t l, sample_t r, logic arm);
      looper_beat_t beat;
      logic [24:0]  env;
      beat.left  = l;
      beat.right = r;
      if (!arm) begin
        loop_mode = MODE_IDLE;
      end else if (loop_mode == MODE_IDLE) begin
        loop_mode = MODE_WAIT;
      end
      beat.mode = loop_mode;
      if (loop_mode == MODE_WAIT) begin
        env = magnitude(l) + magnitude(r);
        if (env > threshold && prev_env <= threshold) begin
          latched = 32'(loop_len);
          if (latched > DEPTH) latched = DEPTH;
          if (latched == 0) latched = 1;
          pos       = 0;
          loop_mode = MODE_REC;
        end
        prev_env = env;
      end else begin
        prev_env = '0;
        if (loop_mode == MODE_REC) begin
          store_l[pos % DEPTH] = l;
          store_r[pos % DEPTH] = r;
          pos++;
          if (pos >= latched) begin
            loop_mode = MODE_PLAY;
            pos       = 0;
          end
        end else if (loop_mode == MODE_PLAY) begin
          beat.left  = store_l[pos % DEPTH];
          beat.right = store_r[pos % DEPTH];
          pos++;
          if (pos >= latched) pos = 0;
        end
      end
      due_beats.push_back(beat);
    endfunction

    function void check_beat(sample_t l, sample_t r, mode_e mode);
      looper_beat_t exp_beat;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat: left %0d right %0d mode %0d", $time, l, r, mode);
        mismatches++;
        return;
      end
      exp_beat = due_beats.pop_front();
      if (l !== exp_beat.left) begin
        $display("%0t: out_left expected %0d, got %0d", $time, exp_beat.left, l);
        mismatches++;
      end
      if (r !== exp_beat.right) begin
        $display("%0t: out_right expected %0d, got %0d", $time, exp_beat.right, r);
        mismatches++;
      end
      if (mode !== exp_beat.mode) begin
        $display("%0t: mode expected %0d, got %0d", $time, exp_beat.mode, mode);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  otsl_in_if  in_ch ();
  otsl_out_if out_ch ();
  otsl_cfg_if cfg_ch ();

  looper_mirror mirror = new();

  bit                           calm_tx;
  bit                           calm_rx;
  int unsigned                  pairs_sent;
  logic [ONSET_THRESHOLD_W-1:0] cur_thr;
  logic [LOOP_SAMPLES_W-1:0]    cur_len;

  onset_triggered_stutter_looper_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic sample_t with_sign(input int unsigned m);
    sample_t v;
    v = m[SAMPLE_BITS_DEF-1:0];
    return (m == HALF_SCALE || $urandom_range(1, 0) == 1) ? -v : v;
  endfunction

  function automatic void pair_at(input int unsigned env, output sample_t l, output sample_t r);
    int unsigned ml;
    ml = $urandom_range(env > HALF_SCALE ? env - HALF_SCALE : 0,
                        env < HALF_SCALE ? env : HALF_SCALE);
    l = with_sign(ml);
    r = with_sign(env - ml);
  endfunction

  task automatic send_pair(input sample_t l, input sample_t r, input logic arm);
    int unsigned gap;
    gap = calm_tx ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      if (in_ch.valid) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_left  <= l;
    in_ch.in_right <= r;
    in_ch.arm      <= arm;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    mirror.take_pair(l, r, arm);
    pairs_sent++;
  endtask

  task automatic drain_results();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (mirror.due_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_looper(input logic [ONSET_THRESHOLD_W-1:0] thr,
                                input logic [LOOP_SAMPLES_W-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ONSET_THRESHOLD;
    cfg_ch.data  <= CFG_DATA_W'(thr);
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    mirror.write_reg(CFG_ONSET_THRESHOLD, CFG_DATA_W'(thr));
    cfg_ch.index <= CFG_LOOP_SAMPLES;
    cfg_ch.data  <= CFG_DATA_W'(len);
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    mirror.write_reg(CFG_LOOP_SAMPLES, CFG_DATA_W'(len));
    cfg_ch.valid <= 1'b0;
    cur_thr = thr;
    cur_len = len;
  endtask

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(7, 0);
      if (stall != 0) begin
        if (out_ch.ready) out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      mirror.check_beat(out_ch.out_left, out_ch.out_right, out_ch.mode);
    end
  end

  initial begin
    sample_t                      l;
    sample_t                      r;
    logic [ONSET_THRESHOLD_W-1:0] thr;
    logic [LOOP_SAMPLES_W-1:0]    len;
    int unsigned                  eff;
    int unsigned                  n_rec;
    int unsigned                  lim;
    int unsigned                  env;
    int unsigned                  base;
    bit                           cut;

    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_left  = '0;
    in_ch.in_right = '0;
    in_ch.arm      = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_ONSET_THRESHOLD;
    cfg_ch.data    = '0;
    cur_thr        = ONSET_THRESHOLD_RST;
    cur_len        = LOOP_SAMPLES_RST;
    pairs_sent     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle passthrough of the sample extremes
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b0);

    // zero threshold, zero length latched as one pair
    drain_results();
    program_looper('0, '0);
    send_pair(0, 0, 1'b1);
    send_pair(1, 0, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(S_MAX, S_MAX, 1'b1);
    send_pair(5, 5, 1'b0);
    send_pair(S_MIN, S_MIN, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(0, 0, 1'b0);

    // full-scale threshold, then lowered below the held envelope
    drain_results();
    program_looper(ONSET_THRESHOLD_W'(ENV_MAX), 17'h1FFFF);
    send_pair(S_MIN, S_MIN, 1'b1);
    send_pair(1000, 0, 1'b1);
    drain_results();
    program_looper(500, 17'h1FFFF);
    send_pair(0, 2000, 1'b1);
    send_pair(100, 0, 1'b1);
    send_pair(-300, -301, 1'b1);
    send_pair(S_MIN, 7, 1'b1);
    send_pair(0, 0, 1'b0);

    // short loop, wrap in playback, rewrite while playing
    drain_results();
    program_looper(100, 3);
    send_pair(60, -40, 1'b1);
    send_pair(-101, 0, 1'b1);
    repeat (7) send_pair(sample_t'($urandom), sample_t'($urandom), 1'b1);
    drain_results();
    program_looper('0, 17'd65536);
    repeat (2) send_pair(sample_t'($urandom), sample_t'($urandom), 1'b1);
    send_pair(0, 0, 1'b0);

    base = pairs_sent;
    while (pairs_sent < base + RANDOM_PAIRS) begin
      calm_tx = ($urandom_range(4, 0) == 0);
      calm_rx = ($urandom_range(4, 0) == 0);
      if ($urandom_range(3, 0) == 0) begin
        drain_results();
        case ($urandom_range(5, 0))
          0:       thr = '0;
          1:       thr = ONSET_THRESHOLD_W'(ENV_MAX);
          2:       thr = ONSET_THRESHOLD_W'($urandom_range(ENV_MAX, 0));
          default: thr = ONSET_THRESHOLD_W'($urandom_range(20000, 0));
        endcase
        case ($urandom_range(9, 0))
          0:       len = '0;
          1:       len = 17'd65536;
          2:       len = 17'h1FFFF;
          3:       len = LOOP_SAMPLES_W'($urandom_range(17'h1FFFF, 0));
          default: len = LOOP_SAMPLES_W'($urandom_range(12, 1));
        endcase
        program_looper(thr, len);
      end
      eff = 32'(cur_len);
      if (eff > DEPTH) eff = DEPTH;
      if (eff == 0) eff = 1;
      if ($urandom_range(3, 0) == 0) begin
        repeat ($urandom_range(20, 5))
          send_pair(sample_t'($urandom), sample_t'($urandom), $urandom_range(3, 0) != 0);
      end else begin
        lim = (32'(cur_thr) < ENV_MAX) ? 32'(cur_thr) : ENV_MAX;
        repeat ($urandom_range(4, 0)) begin
          env = ($urandom_range(3, 0) == 0) ? lim : $urandom_range(lim, 0);
          pair_at(env, l, r);
          send_pair(l, r, 1'b1);
        end
        if (32'(cur_thr) < ENV_MAX) begin
          env = ($urandom_range(3, 0) == 0) ? 32'(cur_thr) + 1
                                            : $urandom_range(ENV_MAX, 32'(cur_thr) + 1);
          pair_at(env, l, r);
          send_pair(l, r, 1'b1);
          cut   = (eff > 64) || ($urandom_range(5, 0) == 0);
          n_rec = cut ? $urandom_range((eff < 20) ? eff : 20, 1) : eff;
          repeat (n_rec) send_pair(sample_t'($urandom), sample_t'($urandom), 1'b1);
          if (cut) begin
            send_pair(sample_t'($urandom), sample_t'($urandom), 1'b0);
          end else begin
            repeat ($urandom_range((3 * eff > 40) ? 40 : 3 * eff, 0))
              send_pair(sample_t'($urandom), sample_t'($urandom), 1'b1);
          end
        end
        if ($urandom_range(3, 0) != 0)
          send_pair(sample_t'($urandom), sample_t'($urandom), 1'b0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.due_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/otsl_pkg.sv
rtl/otsl_in_if.sv
rtl/otsl_out_if.sv
rtl/otsl_cfg_if.sv
rtl/otsl_ram.sv
rtl/otsl_ctrl.sv
rtl/onset_triggered_stutter_looper_top.sv
sim/onset_triggered_stutter_looper_top_tb.sv
